FILE: design/wmv_pkg.sv
// wmv_pkg: widths, defaults and shared types for the welford mean/variance core
// used by wmv_div and welford_mean_variance_core; depends on nothing
package wmv_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int COUNT_W         = 13;
    localparam int VAR_W           = 31;
    localparam int MEAN_W          = 32;
    localparam int SUM_W           = 64;
    localparam int DIV_W           = 64;
    localparam int ITER_W          = 7;
    localparam int MAX_SAMPLES_DEF = 4096;

    // iteration counts of the shared divider
    localparam logic [ITER_W-1:0] ITER_MEAN = ITER_W'(33);
    localparam logic [ITER_W-1:0] ITER_VAR  = ITER_W'(64);

    typedef struct packed {
        logic              start;
        logic [ITER_W-1:0] iters;
    } div_req_t;

endpackage

FILE: design/wmv_div.sv
// wmv_div: radix-2 restoring divider, one quotient bit per cycle
// depends on wmv_pkg; dividend is msb-aligned, quotient lands in the low iters bits
module wmv_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  wmv_pkg::div_req_t           req,
    input  logic [wmv_pkg::DIV_W-1:0]   dividend,
    input  logic [wmv_pkg::COUNT_W-1:0] divisor,
    output logic                        done,
    output logic [wmv_pkg::DIV_W-1:0]   quotient
);
    import wmv_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [ITER_W-1:0]   cnt_reg;
    logic [COUNT_W-1:0]  rem_reg;
    logic [COUNT_W-1:0]  dvs_reg;
    logic [DIV_W-1:0]    dq_reg;

    logic [COUNT_W+1:0]  trial;
    logic                qbit;
    logic [COUNT_W-1:0]  rem_next;

    // trial subtract of the divisor from the shifted partial remainder
    always_comb begin
        trial    = {1'b0, rem_reg, dq_reg[DIV_W-1]} - {2'b00, dvs_reg};
        qbit     = ~trial[COUNT_W+1];
        rem_next = qbit ? trial[COUNT_W-1:0] : {rem_reg[COUNT_W-2:0], dq_reg[DIV_W-1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.iters;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                dq_reg   <= dividend;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                dq_reg  <= {dq_reg[DIV_W-2:0], qbit};
                cnt_reg <= cnt_reg - ITER_W'(1);
                if (cnt_reg == ITER_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

FILE: design/welford_mean_variance_core.sv
// welford_mean_variance_core: one-pass running mean and sample variance, fixed point
// depends on wmv_pkg and wmv_div (shared iterative divider)
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  input   | s_valid s_ready s_sample s_last              | in
//  result  | m_valid m_ready m_mean m_variance            | out
//          | m_sample_count m_overflow                    |
//
// a sample runs from its acceptance through forming the deviation, the shared divider
// (delta / n), then mean update, second deviation, multiply and accumulate; no new
// sample is taken until it is through
// a marked sample then launches the divider for a pass of sum / (n - 1), takes the
// quotient and loads the result register; a set of one sample skips the divider;
// an unmarked dropped sample returns straight to idle
// reset (synchronous, active low) clears the count, mean, sum and flags
// the result register is held while m_ready is low; new samples are still
// taken, and only the next set's result waits for it to drain
module welford_mean_variance_core #(
    parameter int MAX_SAMPLES = wmv_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [wmv_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                s_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [wmv_pkg::SAMPLE_W-1:0] m_mean,
    output logic        [wmv_pkg::VAR_W-1:0]    m_variance,
    output logic        [wmv_pkg::COUNT_W-1:0]  m_sample_count,
    output logic                                m_overflow
);
    import wmv_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_SAMPLES);
    localparam int DEV_W  = MEAN_W + 1;     // deviation, q.24
    localparam int CUT_W  = DEV_W - 8;      // deviation cut to q.16
    localparam int PROD_W = 2 * CUT_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_DIVIDE,
        ST_DEV,
        ST_MULT,
        ST_ACCUM,
        ST_VAR_START,
        ST_VAR_DIV,
        ST_RESULT
    } state_t;

    // truncate a q.24 deviation toward zero to q.16
    function automatic logic signed [CUT_W-1:0] cut_q16(input logic signed [DEV_W-1:0] v);
        logic [DEV_W-1:0] mag;
        logic [CUT_W-1:0] t;
        begin
            mag     = v[DEV_W-1] ? -v : v;
            t       = mag[DEV_W-1:8];
            cut_q16 = v[DEV_W-1] ? -t : t;
        end
    endfunction

    state_t                      state_reg;
    logic signed [SAMPLE_W-1:0]  sample_reg;
    logic                        last_reg;
    logic        [COUNT_W-1:0]   seen_reg;
    logic signed [MEAN_W-1:0]    mean_reg;
    logic        [SUM_W-1:0]     sum_reg;
    logic                        dropped_reg;
    logic signed [DEV_W-1:0]     delta_reg;
    logic signed [CUT_W-1:0]     d1_reg;
    logic signed [CUT_W-1:0]     d2_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic        [VAR_W-1:0]     var_reg;

    logic                        m_valid_reg;
    logic signed [SAMPLE_W-1:0]  m_mean_reg;
    logic        [VAR_W-1:0]     m_var_reg;
    logic        [COUNT_W-1:0]   m_count_reg;
    logic                        m_ovf_reg;

    // shared divider hookup
    div_req_t                    div_req;
    logic        [DIV_W-1:0]     div_dividend;
    logic        [COUNT_W-1:0]   div_divisor;
    logic                        div_done;
    logic        [DIV_W-1:0]     div_quot;

    // datapath
    logic signed [MEAN_W-1:0]    x_q24;
    logic signed [DEV_W-1:0]     dev_c;
    logic        [DEV_W-1:0]     dev_mag;
    logic        [DEV_W:0]       q_signed;
    logic        [DEV_W:0]       mean_sum;
    logic        [SUM_W:0]       var_round;
    logic        [SUM_W-16:0]    var_shift;
    logic        [DEV_W-1:0]     mean_round;
    logic        [SAMPLE_W:0]    mean_q8;
    logic signed [SAMPLE_W-1:0]  mean_sat;
    logic                        s_fire;
    logic                        out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        // sample widened to q8.24, deviation from the current mean
        x_q24   = {sample_reg, 16'h0000};
        dev_c   = {x_q24[MEAN_W-1], x_q24} - {mean_reg[MEAN_W-1], mean_reg};
        dev_mag = dev_c[DEV_W-1] ? -dev_c : dev_c;

        // signed quotient of delta / n, truncated toward zero
        q_signed = delta_reg[DEV_W-1] ? -{1'b0, div_quot[DEV_W-1:0]}
                                      : {1'b0, div_quot[DEV_W-1:0]};
        mean_sum = {{2{mean_reg[MEAN_W-1]}}, mean_reg} + q_signed;

        // variance: round q.32 quotient to q.16, saturate
        var_round = {1'b0, div_quot} + (SUM_W+1)'(32'h0000_8000);
        var_shift = var_round[SUM_W:16];

        // mean: round q8.24 to q8.8, ties upward, saturate at the top
        mean_round = {mean_reg[MEAN_W-1], mean_reg} + DEV_W'(32'h0000_8000);
        mean_q8    = mean_round[DEV_W-1:16];
        mean_sat   = (!mean_q8[SAMPLE_W] && mean_q8[SAMPLE_W-1]) ? 16'sh7FFF
                                                                 : mean_q8[SAMPLE_W-1:0];
    end

    // divider launch: per-sample delta / n or final sum / (n - 1)
    always_comb begin
        div_req.start = 1'b0;
        div_req.iters = ITER_MEAN;
        div_dividend  = {dev_mag, {(DIV_W-DEV_W){1'b0}}};
        div_divisor   = seen_reg + COUNT_W'(1);
        if (state_reg == ST_DELTA) begin
            div_req.start = 1'b1;
        end else if (state_reg == ST_VAR_START) begin
            div_req.start = (seen_reg > COUNT_W'(1));
            div_req.iters = ITER_VAR;
            div_dividend  = sum_reg;
            div_divisor   = seen_reg - COUNT_W'(1);
        end
    end

    wmv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            seen_reg    <= '0;
            mean_reg    <= '0;
            sum_reg     <= '0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // a result taken while the next one is loaded is replaced below
            if (m_valid_reg && m_ready && (state_reg != ST_RESULT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        sample_reg <= s_sample;
                        last_reg   <= s_last;
                        if (seen_reg < MAX_CNT) begin
                            state_reg <= ST_DELTA;
                        end else begin
                            // set already full: drop the sample, still honour last
                            dropped_reg <= 1'b1;
                            state_reg   <= s_last ? ST_VAR_START : ST_IDLE;
                        end
                    end
                end
                ST_DELTA: begin
                    delta_reg <= dev_c;
                    state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE: begin
                    if (div_done) begin
                        mean_reg  <= mean_sum[MEAN_W-1:0];
                        d1_reg    <= cut_q16(delta_reg);
                        state_reg <= ST_DEV;
                    end
                end
                ST_DEV: begin
                    // deviation from the updated mean
                    d2_reg    <= cut_q16(dev_c);
                    state_reg <= ST_MULT;
                end
                ST_MULT: begin
                    prod_reg  <= d1_reg * d2_reg;
                    state_reg <= ST_ACCUM;
                end
                ST_ACCUM: begin
                    if (!prod_reg[PROD_W-1] && (prod_reg != '0)) begin
                        sum_reg <= sum_reg + SUM_W'(unsigned'(prod_reg));
                    end
                    seen_reg  <= seen_reg + COUNT_W'(1);
                    state_reg <= last_reg ? ST_VAR_START : ST_IDLE;
                end
                ST_VAR_START: begin
                    if (seen_reg > COUNT_W'(1)) begin
                        state_reg <= ST_VAR_DIV;
                    end else begin
                        var_reg   <= '0;
                        state_reg <= ST_RESULT;
                    end
                end
                ST_VAR_DIV: begin
                    if (div_done) begin
                        var_reg   <= (|var_shift[SUM_W-16:VAR_W]) ? {VAR_W{1'b1}}
                                                                  : var_shift[VAR_W-1:0];
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    // wait for the result register, then start a fresh set
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_mean_reg  <= mean_sat;
                        m_var_reg   <= var_reg;
                        m_count_reg <= seen_reg;
                        m_ovf_reg   <= dropped_reg;
                        seen_reg    <= '0;
                        mean_reg    <= '0;
                        sum_reg     <= '0;
                        dropped_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_mean         = m_mean_reg;
    assign m_variance     = m_var_reg;
    assign m_sample_count = m_count_reg;
    assign m_overflow     = m_ovf_reg;

endmodule
